// ===== rtl/ddsp_pkg.sv =====
// ----------------------------------------------------------------------------
// ddsp_pkg: shared types and constants of the move planner
// Fixed-point constants, the arctangent table, the segment descriptor and the
// elaboration-time ramp scale function.
// ----------------------------------------------------------------------------
`default_nettype none

package ddsp_pkg;

    localparam int RAMP_STEPS_DEF    = 6;
    localparam int CORDIC_ROUNDS_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int SQRT_ITERS        = 24;
    localparam int QUEUE_DEPTH       = 4;
    localparam int VEL_W             = 48;
    localparam int PEAK_W            = 46;
    localparam int DIV_N             = 72;
    localparam int DIV_D             = 34;

    localparam logic [15:0] TURN_MIN        = 16'd11;
    localparam logic [23:0] DIST_MIN_Q8     = 24'd26;
    localparam logic [47:0] VEL_MIN_Q16     = 48'd656;
    localparam logic [26:0] TWO_PI_Q24      = 27'd105414357;
    localparam logic [21:0] RAD2DEG_Q16     = 22'd3754936;
    localparam longint      CORDIC_GAIN_Q30 = 64'sd652032874;
    localparam logic [45:0] PEAK_CAP        = 46'h2000_0000_0000;
    localparam logic [22:0] RATE_MAX        = 23'h7F_FFFF;
    localparam logic [15:0] REPEAT_MAX      = 16'hFFFF;
    localparam logic [16:0] SCALE_ONE       = 17'h1_0000;

    localparam logic KIND_TURN = 1'b0;
    localparam logic KIND_FWD  = 1'b1;

    typedef enum logic [1:0] {
        REG_HALF_TRACK = 2'd0,
        REG_RIM_RADIUS = 2'd1,
        REG_RATE_HZ    = 2'd2,
        REG_MAX_SPEED  = 2'd3
    } t_reg_idx;

    // atan(2^-i), full circle = 2^32
    localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [15:0] half_track;
        logic [15:0] rim_radius;
        logic [15:0] rate_hz;
        logic [15:0] max_speed;
    } t_cfg;

    typedef struct packed {
        logic [VEL_W-1:0] vel;
        logic             neg_l;
        logic             neg_r;
        logic             kind;
        logic             last;
    } t_seg;

    // (1 - cos(th)) / 2 in Q16, th in [0, 2^31] with 2^31 = pi.
    // Used only to build constant tables.
    function automatic logic [16:0] scale_of(logic [31:0] th_in, int rounds);
        longint     x;
        longint     y;
        longint     z;
        longint     t;
        longint     tmp;
        logic [31:0] th;
        logic        neg;
        th  = th_in;
        neg = 1'b0;
        if (th > 32'h4000_0000) begin
            th  = 32'h8000_0000 - th;
            neg = 1'b1;
        end
        x = CORDIC_GAIN_Q30;
        y = 0;
        z = longint'({32'd0, th});
        for (int i = 0; i < ATAN_ENTRIES; i++) begin
            if (i < rounds) begin
                if (z >= 0) begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - longint'({32'd0, ATAN_TAB[i]});
                end else begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + longint'({32'd0, ATAN_TAB[i]});
                end
                x = t;
            end
        end
        if (neg) begin
            x = -x;
        end
        tmp = (64'sd1 <<< 30) - x + (64'sd1 <<< 14);
        if (tmp < 0) begin
            tmp = 0;
        end
        tmp = tmp >>> 15;
        if (tmp > 65536) begin
            tmp = 65536;
        end
        return tmp[16:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ddsp_front.sv =====
// ----------------------------------------------------------------------------
// ddsp_front: move intake and segment classification
// Finds distance (bit-serial square root) and heading (vectoring CORDIC),
// works out both segment speeds and queues the segments that produce output.
// ----------------------------------------------------------------------------
`default_nettype none

module ddsp_front #(
    parameter int CordicRounds = ddsp_pkg::CORDIC_ROUNDS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [15:0]   i_dx,
    input  wire logic [15:0]   i_dy,
    input  wire ddsp_pkg::t_cfg i_cfg,
    output logic               o_push,
    output ddsp_pkg::t_seg     o_seg,
    input  wire logic          i_full
);
    import ddsp_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_SQ1    = 10'b00_0000_0010,
        S_SQ2    = 10'b00_0000_0100,
        S_RUN    = 10'b00_0000_1000,
        S_HEAD   = 10'b00_0001_0000,
        S_TM1    = 10'b00_0010_0000,
        S_TM2    = 10'b00_0100_0000,
        S_FM     = 10'b00_1000_0000,
        S_PUSH_T = 10'b01_0000_0000,
        S_PUSH_F = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    logic [4:0]  r_cnt;
    logic signed [15:0] r_dx, r_dy;
    logic signed [39:0] r_x, r_y;
    logic [31:0] r_z;
    logic        r_zero;
    logic [31:0] r_sq;
    logic [47:0] r_rem, r_root, r_bit;
    logic [15:0] r_heading;
    logic [31:0] r_p1;
    logic [41:0] r_t, r_vt;
    logic [47:0] r_vf;
    logic        r_big, r_neg_l, r_neg_r;

    logic signed [39:0] w_x0, w_y0;
    logic [47:0] w_try;
    logic [31:0] w_zr;
    logic [15:0] w_target, w_diff, w_abs;
    logic [58:0] w_tm;
    logic [57:0] w_vm;
    logic [39:0] w_fm;
    logic        w_turn_ok, w_fwd_ok;

    assign w_x0 = {{8{i_dx[15]}}, i_dx, 16'h0};
    assign w_y0 = {{8{i_dy[15]}}, i_dy, 16'h0};
    assign w_try = r_root + r_bit;
    assign w_zr = r_z + 32'h0000_8000;
    assign w_target = r_zero ? 16'h0 : w_zr[31:16];
    assign w_diff = w_target - r_heading;
    assign w_abs = w_diff[15] ? (16'h0 - w_diff) : w_diff;
    assign w_tm = {27'd0, r_p1} * {32'd0, TWO_PI_Q24};
    assign w_vm = {16'd0, r_t} * {42'd0, i_cfg.rate_hz};
    assign w_fm = r_root[23:0] * i_cfg.rate_hz;
    assign w_turn_ok = r_big && ({6'd0, r_vt} >= VEL_MIN_Q16);
    assign w_fwd_ok = (r_root[23:0] >= DIST_MIN_Q8) && (r_vf >= VEL_MIN_Q16);

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_push = 1'b0;
        o_seg  = '0;
        if (r_state == S_PUSH_T) begin
            o_push      = w_turn_ok && !i_full;
            o_seg.vel   = {6'd0, r_vt};
            o_seg.neg_l = r_neg_l;
            o_seg.neg_r = r_neg_r;
            o_seg.kind  = KIND_TURN;
            o_seg.last  = !w_fwd_ok;
        end else if (r_state == S_PUSH_F) begin
            o_push     = w_fwd_ok && !i_full;
            o_seg.vel  = r_vf;
            o_seg.kind = KIND_FWD;
            o_seg.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_heading <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_dx   <= i_dx;
                        r_dy   <= i_dy;
                        r_zero <= (i_dx == 16'h0) && (i_dy == 16'h0);
                        if (w_x0 < 0) begin
                            r_x <= -w_x0;
                            r_y <= -w_y0;
                            r_z <= 32'h8000_0000;
                        end else begin
                            r_x <= w_x0;
                            r_y <= w_y0;
                            r_z <= 32'h0;
                        end
                        r_state <= S_SQ1;
                    end
                end
                S_SQ1: begin
                    r_sq    <= r_dx * r_dx;
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_rem   <= {r_sq + 32'(r_dy * r_dy), 16'h0};
                    r_root  <= '0;
                    r_bit   <= 48'h1 << 46;
                    r_cnt   <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (r_rem >= w_try) begin
                        r_rem  <= r_rem - w_try;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (32'(r_cnt) < CordicRounds) begin
                        if (!r_y[39]) begin
                            r_x <= r_x + (r_y >>> r_cnt);
                            r_y <= r_y - (r_x >>> r_cnt);
                            r_z <= r_z + ATAN_TAB[r_cnt];
                        end else begin
                            r_x <= r_x - (r_y >>> r_cnt);
                            r_y <= r_y + (r_x >>> r_cnt);
                            r_z <= r_z - ATAN_TAB[r_cnt];
                        end
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(SQRT_ITERS - 1)) begin
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    // The heading follows the target even when no turn is emitted.
                    r_heading <= w_target;
                    r_big     <= (w_abs >= TURN_MIN);
                    r_neg_l   <= !w_diff[15] && (w_diff != 16'h0);
                    r_neg_r   <= w_diff[15];
                    r_p1      <= w_abs * i_cfg.half_track;
                    r_state   <= S_TM1;
                end
                S_TM1: begin
                    r_t     <= w_tm[57:16];
                    r_state <= S_TM2;
                end
                S_TM2: begin
                    r_vt    <= w_vm[57:16];
                    r_state <= S_FM;
                end
                S_FM: begin
                    r_vf    <= {w_fm, 8'h0};
                    r_state <= S_PUSH_T;
                end
                S_PUSH_T: begin
                    if (!w_turn_ok || !i_full) begin
                        r_state <= S_PUSH_F;
                    end
                end
                S_PUSH_F: begin
                    if (!w_fwd_ok || !i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ddsp_queue.sv =====
// ----------------------------------------------------------------------------
// ddsp_queue: segment queue
// A small first-in first-out buffer of segment descriptors with show-ahead read.
// ----------------------------------------------------------------------------
`default_nettype none

module ddsp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ddsp_pkg::t_seg i_seg,
    output logic                o_full,
    input  wire logic           i_pop,
    output ddsp_pkg::t_seg      o_seg,
    output logic                o_empty
);
    import ddsp_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_seg        r_mem [QUEUE_DEPTH];
    logic [AW:0] r_wr, r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[AW] != r_rd[AW]) && (r_wr[AW-1:0] == r_rd[AW-1:0]);
    assign o_seg   = r_mem[r_rd[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[AW-1:0]] <= i_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ddsp_div.sv =====
// ----------------------------------------------------------------------------
// ddsp_div: shared unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ddsp_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [ddsp_pkg::DIV_N-1:0] i_dividend,
    input  wire logic [ddsp_pkg::DIV_D-1:0] i_divisor,
    output logic                            o_done,
    output logic [ddsp_pkg::DIV_N-1:0]      o_quotient
);
    import ddsp_pkg::*;

    localparam int CW = $clog2(DIV_N + 1);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [DIV_N-1:0] r_dvd;
    logic [DIV_D-1:0] r_dvs;
    logic [DIV_D:0]   r_rem;
    logic [DIV_D:0]   w_sh;
    logic [DIV_D+1:0] w_diff;

    assign w_sh   = {r_rem[DIV_D-1:0], r_dvd[DIV_N-1]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_dvs};
    assign o_done = r_done;
    assign o_quotient = r_dvd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!w_diff[DIV_D+1]) begin
                    r_rem <= w_diff[DIV_D:0];
                    r_dvd <= {r_dvd[DIV_N-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_dvd <= {r_dvd[DIV_N-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ddsp_back.sv =====
// ----------------------------------------------------------------------------
// ddsp_back: S-curve profile generator
// Takes one queued segment, finds cruise count and peak wheel rate, and emits
// the ramp-up, cruise (when there is one) and ramp-down results through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddsp_back #(
    parameter int RampSteps    = ddsp_pkg::RAMP_STEPS_DEF,
    parameter int CordicRounds = ddsp_pkg::CORDIC_ROUNDS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ddsp_pkg::t_cfg i_cfg,
    input  wire ddsp_pkg::t_seg i_seg,
    input  wire logic           i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [63:0]         o_data,
    output logic                o_last,
    output logic                o_kind
);
    import ddsp_pkg::*;

    localparam int JW = $clog2(2 * RampSteps);
    localparam int KW = $clog2(RampSteps + 1);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_CDS  = 12'b0000_0000_0010,
        S_CDW  = 12'b0000_0000_0100,
        S_PDS  = 12'b0000_0000_1000,
        S_PDW  = 12'b0000_0001_0000,
        S_ML   = 12'b0000_0010_0000,
        S_MH   = 12'b0000_0100_0000,
        S_RDS  = 12'b0000_1000_0000,
        S_RDW  = 12'b0001_0000_0000,
        S_EA   = 12'b0010_0000_0000,
        S_EB   = 12'b0100_0000_0000,
        S_EO   = 12'b1000_0000_0000
    } t_state;

    logic [16:0] w_scale [RampSteps + 1];

    for (genvar k = 0; k <= RampSteps; k++) begin : g_scale
        localparam logic [31:0] TH = 32'((64'(k) * 64'h8000_0000) / 64'(RampSteps));
        assign w_scale[k] = scale_of(TH, CordicRounds);
    end

    t_state r_state;
    t_seg   r_seg;
    logic [DIV_D-1:0]  r_cruise;
    logic [PEAK_W-1:0] r_peak;
    logic [67:0]       r_prod;
    logic [39:0]       r_ml;
    logic [22:0]       r_mag;
    logic [JW-1:0]     r_j;
    logic              r_ovalid, r_olast, r_okind;
    logic [63:0]       r_odata;

    logic              w_start;
    logic [DIV_N-1:0]  w_dvd, w_q;
    logic [DIV_D-1:0]  w_dvs;
    logic              w_done;
    logic [15:0]       w_lin, w_rw;
    logic [31:0]       w_unit;
    logic [39:0]       w_ramp;
    logic [JW:0]       w_jx, w_kx, w_jn;
    logic [16:0]       w_s;
    logic              w_cruise_step;
    logic [63:0]       w_sum, w_pk;
    logic [23:0]       w_mag24, w_neg24;
    logic [15:0]       w_rep;
    logic              w_out_free;

    assign w_lin  = (i_cfg.max_speed == 16'h0) ? 16'd1 : i_cfg.max_speed;
    assign w_rw   = (i_cfg.rim_radius == 16'h0) ? 16'd1 : i_cfg.rim_radius;
    assign w_unit = {w_lin, 16'h0};
    assign w_ramp = 40'(RampSteps) * {8'd0, w_unit};

    assign w_jx = {1'b0, r_j};
    assign w_cruise_step = (w_jx == (JW+1)'(RampSteps));
    assign w_kx = (w_jx < (JW+1)'(RampSteps)) ? (w_jx + 1'b1)
                                              : ((JW+1)'(2 * RampSteps) - w_jx);
    assign w_s  = w_cruise_step ? SCALE_ONE : w_scale[w_kx[KW-1:0]];

    // Skip the cruise slot when the segment has no cruise.
    always_comb begin
        w_jn = w_jx + 1'b1;
        if ((w_jn == (JW+1)'(RampSteps)) && (r_cruise == '0)) begin
            w_jn = w_jx + 2'd2;
        end
    end

    assign w_sum = {1'b0, 40'(r_peak[45:23] * w_s), 23'h0} + {24'd0, r_ml} + 64'h80_0000;
    assign w_pk  = w_q[DIV_N-1:8];
    assign w_mag24 = {1'b0, r_mag};
    assign w_neg24 = 24'h0 - w_mag24;
    assign w_rep = !w_cruise_step ? 16'd1
                 : ((r_cruise > DIV_D'(REPEAT_MAX)) ? REPEAT_MAX : r_cruise[15:0]);
    assign w_out_free = !r_ovalid || i_ready;

    always_comb begin
        w_start = 1'b0;
        w_dvd   = '0;
        w_dvs   = '0;
        unique case (r_state)
            S_CDS: begin
                w_start = ({8'd0, r_seg.vel} >= {16'd0, w_ramp});
                w_dvd   = DIV_N'({8'd0, r_seg.vel} - {16'd0, w_ramp}
                                 + {24'd0, w_unit} - 56'd1);
                w_dvs   = DIV_D'(w_unit);
            end
            S_PDS: begin
                w_start = 1'b1;
                w_dvd   = DIV_N'(r_seg.vel);
                w_dvs   = DIV_D'(RampSteps) + r_cruise;
            end
            S_RDS: begin
                w_start = 1'b1;
                w_dvd   = DIV_N'(r_prod);
                w_dvs   = DIV_D'(w_rw);
            end
            default: ;
        endcase
    end

    ddsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_done),
        .o_quotient (w_q)
    );

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_last  = r_olast;
    assign o_kind  = r_okind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_j      <= '0;
        end else begin
            // In S_EO the output register is reloaded below instead.
            if (r_ovalid && i_ready && (r_state != S_EO)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_seg   <= i_seg;
                        r_state <= S_CDS;
                    end
                end
                S_CDS: begin
                    r_cruise <= '0;
                    r_state  <= w_start ? S_CDW : S_PDS;
                end
                S_CDW: begin
                    if (w_done) begin
                        r_cruise <= w_q[DIV_D-1:0];
                        r_state  <= S_PDS;
                    end
                end
                S_PDS: r_state <= S_PDW;
                S_PDW: begin
                    if (w_done) begin
                        r_peak  <= w_q[PEAK_W-1:0];
                        r_state <= S_ML;
                    end
                end
                S_ML: begin
                    r_prod  <= 68'(r_peak[22:0] * RAD2DEG_Q16);
                    r_state <= S_MH;
                end
                S_MH: begin
                    r_prod  <= r_prod + {45'(r_peak[45:23] * RAD2DEG_Q16), 23'h0};
                    r_state <= S_RDS;
                end
                S_RDS: r_state <= S_RDW;
                S_RDW: begin
                    if (w_done) begin
                        r_peak  <= (w_pk > {18'd0, PEAK_CAP}) ? PEAK_CAP : w_pk[PEAK_W-1:0];
                        r_j     <= '0;
                        r_state <= S_EA;
                    end
                end
                S_EA: begin
                    r_ml    <= r_peak[22:0] * w_s;
                    r_state <= S_EB;
                end
                S_EB: begin
                    r_mag   <= (w_sum[63:24] > {17'd0, RATE_MAX}) ? RATE_MAX : w_sum[46:24];
                    r_state <= S_EO;
                end
                S_EO: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {w_rep,
                                     r_seg.neg_r ? w_neg24 : w_mag24,
                                     r_seg.neg_l ? w_neg24 : w_mag24};
                        r_okind  <= r_seg.kind;
                        r_olast  <= r_seg.last && (w_jx == (JW+1)'(2 * RampSteps - 1));
                        if (w_jx == (JW+1)'(2 * RampSteps - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= w_jn[JW-1:0];
                            r_state <= S_EA;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/diff_drive_s_curve_move_planner.sv =====
// ----------------------------------------------------------------------------
// diff_drive_s_curve_move_planner: differential-drive S-curve move planner
// Turns relative moves into turn and forward wheel-rate profiles.
// ----------------------------------------------------------------------------
// Each accepted move (dx, dy in mm) passes through the intake, which finds the
// distance by a 24-step square root and the heading by CORDIC, then queues
// up to two segments; the intake takes no new move until it is
// done with the last one. Each segment then takes two or three passes
// through the one-bit-per-cycle divider (cruise count when the segment is
// long enough, peak speed, degree conversion), then a multiply, a sum and
// an output register load for each emitted result. The intake takes the
// next move while the generator still works, as long as the segment queue
// has room. Results carry the left and right wheel rates, the repeat count,
// the segment kind in tuser and the end of the move in tlast. Registers sit
// on an APB port at byte addresses 0, 4, 8, 12.
// ----------------------------------------------------------------------------
`default_nettype none

module diff_drive_s_curve_move_planner #(
    parameter int RAMP_STEPS    = ddsp_pkg::RAMP_STEPS_DEF,
    parameter int CORDIC_ROUNDS = ddsp_pkg::CORDIC_ROUNDS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // move_dx, move_dy
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // left_wheel_rate, right_wheel_rate, repeat_count
    output logic             m_axis_tlast,
    output logic             m_axis_tuser,   // segment_kind
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ddsp_pkg::*;

    t_cfg r_cfg;
    t_seg w_push_seg, w_q_seg;
    logic w_push, w_full, w_pop, w_empty;
    t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (w_idx)
            REG_HALF_TRACK: prdata = {16'h0, r_cfg.half_track};
            REG_RIM_RADIUS: prdata = {16'h0, r_cfg.rim_radius};
            REG_RATE_HZ:    prdata = {16'h0, r_cfg.rate_hz};
            REG_MAX_SPEED:  prdata = {16'h0, r_cfg.max_speed};
            default:        prdata = 32'h0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_track <= 16'd12800;
            r_cfg.rim_radius <= 16'd6400;
            r_cfg.rate_hz    <= 16'd100;
            r_cfg.max_speed  <= 16'd50;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                REG_HALF_TRACK: r_cfg.half_track <= pwdata[15:0];
                REG_RIM_RADIUS: r_cfg.rim_radius <= pwdata[15:0];
                REG_RATE_HZ:    r_cfg.rate_hz    <= pwdata[15:0];
                REG_MAX_SPEED:  r_cfg.max_speed  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    ddsp_front #(
        .CordicRounds (CORDIC_ROUNDS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_dx    (s_axis_tdata[15:0]),
        .i_dy    (s_axis_tdata[31:16]),
        .i_cfg   (r_cfg),
        .o_push  (w_push),
        .o_seg   (w_push_seg),
        .i_full  (w_full)
    );

    ddsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_seg   (w_push_seg),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_seg   (w_q_seg),
        .o_empty (w_empty)
    );

    ddsp_back #(
        .RampSteps    (RAMP_STEPS),
        .CordicRounds (CORDIC_ROUNDS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_seg   (w_q_seg),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_kind  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== dv/diff_drive_s_curve_move_planner_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// diff_drive_s_curve_move_planner_tb: self-checking bench of the move planner
// Drives relative moves in bursts, stalls the result stream, and compares
// every wheel-rate transaction against a local fixed-point planner model
// across several register settings.
// ----------------------------------------------------------------------------
module diff_drive_s_curve_move_planner_tb;
    import ddsp_pkg::*;

    localparam int      STEPS       = 6;
    localparam int      ROUNDS      = 16;
    localparam int      SETTLE      = 700;
    localparam int      IDLE_LIMIT  = 20000;
    localparam longint  MIN_TURN    = 11;
    localparam longint  MIN_DIST    = 26;
    localparam longint  MIN_SPEED   = 656;
    localparam longint  TWO_PI_FX   = 105414357;
    localparam longint  DEG_PER_RAD = 3754936;
    localparam longint  GAIN_FX     = 652032874;
    localparam longint  CAP_PEAK    = 64'h2000_0000_0000;

    localparam logic [31:0] ARC [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct {
        logic [23:0] left;
        logic [23:0] right;
        logic [15:0] repeats;
        logic        kind;
        logic        last;
    } t_wheel_rate;

    typedef struct {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        bit                 quiet;
    } t_move_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // move_dx, move_dy
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // left_wheel_rate, right_wheel_rate, repeat_count
    logic        m_axis_tlast;
    logic        m_axis_tuser;   // segment_kind
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    diff_drive_s_curve_move_planner i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    t_wheel_rate expected_rates[$];
    int          error_count = 0;
    bit          hold_request = 0;

    logic [15:0] cfg_half_track;
    logic [15:0] cfg_rim_radius;
    logic [15:0] cfg_rate_hz;
    logic [15:0] cfg_max_speed;
    logic [15:0] robot_heading;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // ---------------- planner model ----------------

    function automatic longint shift_right_signed(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [15:0] target_heading(longint dx, longint dy);
        longint      x;
        longint      y;
        longint      t;
        logic [31:0] ang;
        logic [31:0] rounded;
        if (dx == 0 && dy == 0) return 16'd0;
        x   = dx * 65536;
        y   = dy * 65536;
        ang = 32'd0;
        if (x < 0) begin
            x   = -x;
            y   = -y;
            ang = 32'h8000_0000;
        end
        for (int i = 0; i < ROUNDS; i++) begin
            if (y >= 0) begin
                t   = x + shift_right_signed(y, i);
                y   = y - shift_right_signed(x, i);
                ang = ang + ARC[i];
            end else begin
                t   = x - shift_right_signed(y, i);
                y   = y + shift_right_signed(x, i);
                ang = ang - ARC[i];
            end
            x = t;
        end
        rounded = ang + 32'h8000;
        return rounded[31:16];
    endfunction

    // Raised-cosine ramp weight (1 - cos(pi*k/STEPS)) / 2 in Q16.
    function automatic longint ramp_weight(int k);
        longint th;
        longint x;
        longint y;
        longint z;
        longint t;
        longint tmp;
        bit     flip;
        th   = (longint'(k) * 64'h8000_0000) / STEPS;
        flip = 1'b0;
        if (th > 64'h4000_0000) begin
            th   = 64'h8000_0000 - th;
            flip = 1'b1;
        end
        x = GAIN_FX;
        y = 0;
        z = th;
        for (int i = 0; i < ROUNDS; i++) begin
            if (z >= 0) begin
                t = x - shift_right_signed(y, i);
                y = y + shift_right_signed(x, i);
                z = z - longint'(ARC[i]);
            end else begin
                t = x + shift_right_signed(y, i);
                y = y - shift_right_signed(x, i);
                z = z + longint'(ARC[i]);
            end
            x = t;
        end
        if (flip) x = -x;
        tmp = (64'sd1 <<< 30) - x + (64'sd1 <<< 14);
        if (tmp < 0) tmp = 0;
        tmp = tmp >>> 15;
        return (tmp > 65536) ? 65536 : tmp;
    endfunction

    function automatic void push_rate(longint unsigned peak, longint unsigned weight,
                                      bit back_l, bit back_r, longint unsigned reps,
                                      bit kind);
        longint unsigned mag;
        t_wheel_rate     r;
        mag = (peak * weight + (64'd1 << 23)) >> 24;
        if (mag > 64'd8388607) mag = 64'd8388607;
        r.left    = back_l ? 24'(-mag) : 24'(mag);
        r.right   = back_r ? 24'(-mag) : 24'(mag);
        r.repeats = reps[15:0];
        r.kind    = kind;
        r.last    = 1'b0;
        expected_rates.push_back(r);
    endfunction

    function automatic int plan_segment(longint unsigned v, bit back_l, bit back_r,
                                        bit kind);
        longint unsigned lin;
        longint unsigned radius;
        longint unsigned unit_speed;
        longint unsigned ramp_speed;
        longint unsigned cruise;
        longint unsigned peak;
        int              count;
        lin        = (cfg_max_speed == 0) ? 1 : cfg_max_speed;
        radius     = (cfg_rim_radius == 0) ? 1 : cfg_rim_radius;
        unit_speed = lin << 16;
        ramp_speed = STEPS * unit_speed;
        cruise     = 0;
        count      = 0;
        if (v < MIN_SPEED) return 0;
        if (v >= ramp_speed) cruise = (v - ramp_speed + unit_speed - 1) / unit_speed;
        peak = v / (STEPS + cruise);
        peak = (peak * DEG_PER_RAD / radius) >> 8;
        if (peak > CAP_PEAK) peak = CAP_PEAK;
        for (int k = 1; k <= STEPS; k++) begin
            push_rate(peak, ramp_weight(k), back_l, back_r, 1, kind);
            count++;
        end
        if (cruise != 0) begin
            push_rate(peak, 65536, back_l, back_r,
                      (cruise > 65535) ? 65535 : cruise, kind);
            count++;
        end
        for (int k = STEPS - 1; k >= 1; k--) begin
            push_rate(peak, ramp_weight(k), back_l, back_r, 1, kind);
            count++;
        end
        return count;
    endfunction

    // Queues the wheel rates that one move produces; returns how many.
    function automatic int plan_move(logic signed [15:0] dx, logic signed [15:0] dy);
        longint          sdx;
        longint          sdy;
        longint unsigned dist_q8;
        logic [15:0]     target;
        logic [15:0]     diff;
        longint          delta;
        longint unsigned mag;
        longint unsigned turn_speed;
        int              count;
        sdx     = dx;
        sdy     = dy;
        dist_q8 = floor_sqrt(longint'(sdx * sdx + sdy * sdy) << 16);
        target  = target_heading(sdx, sdy);
        diff    = target - robot_heading;
        delta   = diff[15] ? longint'(diff) - 65536 : longint'(diff);
        count   = 0;
        robot_heading = target;
        if (delta >= MIN_TURN || delta <= -MIN_TURN) begin
            mag        = (delta < 0) ? -delta : delta;
            turn_speed = (mag * cfg_half_track * TWO_PI_FX) >> 16;
            turn_speed = (turn_speed * cfg_rate_hz) >> 16;
            count += plan_segment(turn_speed, delta > 0, delta < 0, KIND_TURN);
        end
        if (dist_q8 >= MIN_DIST) begin
            count += plan_segment(dist_q8 * cfg_rate_hz * 256, 1'b0, 1'b0, KIND_FWD);
        end
        if (count > 0) expected_rates[$].last = 1'b1;
        return count;
    endfunction

    // ---------------- drivers ----------------

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HALF_TRACK: cfg_half_track = value;
            REG_RIM_RADIUS: cfg_rim_radius = value;
            REG_RATE_HZ:    cfg_rate_hz    = value;
            REG_MAX_SPEED:  cfg_max_speed  = value;
        endcase
    endtask

    task automatic set_geometry(input logic [15:0] half, input logic [15:0] radius,
                                input logic [15:0] rate, input logic [15:0] speed);
        write_reg(REG_HALF_TRACK, half);
        write_reg(REG_RIM_RADIUS, radius);
        write_reg(REG_RATE_HZ, rate);
        write_reg(REG_MAX_SPEED, speed);
    endtask

    // Wait for all rates, then give a move with no output time to finish.
    task automatic drain_planner();
        s_axis_tvalid <= 1'b0;
        while (expected_rates.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    int burst_left = 0;

    task automatic send_move(input logic signed [15:0] dx, input logic signed [15:0] dy,
                             output int produced);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dy, dx};
        do @(posedge i_clk); while (!s_axis_tready);
        produced = plan_move(dx, dy);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            burst_left = $urandom_range(0, 10);
        end
    endtask

    function automatic logic signed [15:0] random_coord();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 400)) - 16'sd200;
            2:       return 16'sd0;
            3:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom_range(0, 8000)) - 16'sd4000;
        endcase
    endfunction

    task automatic random_moves(input int count);
        int produced;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        for (int i = 0; i < count; i++) begin
            dx = random_coord();
            dy = random_coord();
            // Moves along x with a tiny sideways offset probe the small-turn limit.
            if ($urandom_range(0, 7) == 0) begin
                dx = 16'sd5000;
                dy = 16'($urandom_range(0, 6)) - 16'sd3;
            end
            send_move(dx, dy, produced);
        end
    endtask

    // ---------------- stimulus ----------------

    t_move_row directed_moves[] = '{
        '{16'sd0,      16'sd0,      1'b1},   // zero move from reset heading
        '{16'sd100,    16'sd0,      1'b0},
        '{16'sd0,      16'sd100,    1'b0},
        '{16'sd0,      16'sd0,      1'b0},   // turn back to zero heading
        '{16'sd0,      16'sd0,      1'b1},
        '{-16'sd100,   16'sd0,      1'b0},   // half turn
        '{16'sd100,    16'sd0,      1'b0},   // half turn back, in the same direction
        '{16'sd1000,   16'sd1,      1'b0},   // turn below the threshold
        '{16'sd1,      16'sd0,      1'b0},
        '{16'sh7FFF,   16'sh7FFF,   1'b0},
        '{16'sh8000,   16'sh8000,   1'b0},
        '{16'sh8000,   16'sh7FFF,   1'b0},
        '{16'sh7FFF,   16'sh8000,   1'b0},
        '{16'sh8000,   16'sd0,      1'b0},
        '{16'sd0,      16'sh8000,   1'b0},
        '{16'sd0,      16'sh7FFF,   1'b0},
        '{-16'sd1,     -16'sd1,     1'b0},
        '{16'sd300,    16'sd0,      1'b0},
        '{16'sd0,      -16'sd20,    1'b0}
    };

    initial begin
        int produced;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 32'd0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 4'd0;
        pwdata        = 32'd0;
        cfg_half_track = 16'd12800;
        cfg_rim_radius = 16'd6400;
        cfg_rate_hz    = 16'd100;
        cfg_max_speed  = 16'd50;
        robot_heading  = 16'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_moves[i]) begin
            send_move(directed_moves[i].dx, directed_moves[i].dy, produced);
            if (directed_moves[i].quiet && produced != 0)
                report_mismatch($sformatf("row %0d should produce no rates", i));
        end
        drain_planner();

        // Long receiver hold while moves keep coming, so the intake backs up.
        hold_request = 1'b1;
        random_moves(25);
        hold_request = 1'b0;
        drain_planner();

        set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_moves(25);
        drain_planner();
        set_geometry(16'd1, 16'd1, 16'd1, 16'd1);   // mostly slow segments
        random_moves(25);
        drain_planner();
        set_geometry(16'hFFFF, 16'd1, 16'hFFFF, 16'd1);   // long saturated cruises
        random_moves(20);
        drain_planner();
        set_geometry(16'd12800, 16'd6400, 16'd1000, 16'd1);
        random_moves(25);
        drain_planner();
        for (int p = 0; p < 4; p++) begin
            set_geometry(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                         16'($urandom_range(1, 2000)), 16'($urandom_range(1, 65535)));
            random_moves(25);
            drain_planner();
        end

        if (error_count == 0)
            $display("diff_drive_s_curve_move_planner test passed");
        else
            $display("diff_drive_s_curve_move_planner test failed");
        $finish;
    end

    // ---------------- receiver ----------------

    int  stall_mode = 0;
    int  mode_left  = 0;
    int  hold_left  = 0;
    bit  hold_done  = 0;

    always @(posedge i_clk) begin
        if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 1500;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(50, 300);
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 9) < 6);
                default: m_axis_tready <= (mode_left % 4 != 0);
            endcase
        end
    end

    // ---------------- checker ----------------

    always @(posedge i_clk) begin
        t_wheel_rate want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_rates.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction %h", m_axis_tdata));
            end else begin
                want = expected_rates.pop_front();
                if (m_axis_tdata[23:0] !== want.left)
                    report_mismatch($sformatf("left rate %h, want %h",
                                              m_axis_tdata[23:0], want.left));
                if (m_axis_tdata[47:24] !== want.right)
                    report_mismatch($sformatf("right rate %h, want %h",
                                              m_axis_tdata[47:24], want.right));
                if (m_axis_tdata[63:48] !== want.repeats)
                    report_mismatch($sformatf("repeat count %0d, want %0d",
                                              m_axis_tdata[63:48], want.repeats));
                if (m_axis_tuser !== want.kind)
                    report_mismatch($sformatf("segment kind %b, want %b",
                                              m_axis_tuser, want.kind));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last flag %b, want %b",
                                              m_axis_tlast, want.last));
            end
        end
    end

    // ---------------- watchdog ----------------

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("diff_drive_s_curve_move_planner test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
